// ----- rtl/apls_pkg.sv -----
package apls_pkg;

   // Field and register widths
   localparam int SAMPLE_W   = 12;
   localparam int BREAK_W    = 12;
   localparam int VALUE_W    = 16;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 16;
   localparam int NUM_BREAKS = 5;
   localparam int NUM_SEGS   = 4;

   // Internal arithmetic widths
   localparam int LEVEL_W = 19;   // value_at_first + 4 * value_step
   localparam int ACC_W   = 32;   // interpolation numerator
   localparam int DIV_W   = 32;   // divider dividend and quotient
   localparam int DEN_W   = 12;   // divider divisor

   localparam int SAMPLES_PER_RESULT_DEF = 16;

   // Register indexes
   localparam logic [CFG_IDX_W-1:0] REG_BREAK_0    = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_BREAK_1    = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_BREAK_2    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_BREAK_3    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_BREAK_4    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_VALUE_BASE = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_VALUE_STEP = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_OPEN_LIMIT = 3'd7;

   // Register reset values
   localparam logic [BREAK_W-1:0] BREAK_0_RST    = 12'd161;
   localparam logic [BREAK_W-1:0] BREAK_1_RST    = 12'd776;
   localparam logic [BREAK_W-1:0] BREAK_2_RST    = 12'd1167;
   localparam logic [BREAK_W-1:0] BREAK_3_RST    = 12'd1471;
   localparam logic [BREAK_W-1:0] BREAK_4_RST    = 12'd1613;
   localparam logic [VALUE_W-1:0] VALUE_BASE_RST = 16'd0;
   localparam logic [VALUE_W-1:0] VALUE_STEP_RST = 16'd512;
   localparam logic [BREAK_W-1:0] OPEN_LIMIT_RST = 12'd2000;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_AVERAGE,
      ST_SEGMENT,
      ST_MUL_LEVEL,
      ST_MUL_SLOPE,
      ST_NUM_START,
      ST_NUM_WAIT,
      ST_FINISH
   } apls_state_type;

   typedef struct packed {
      logic             take;
      logic             div_start;
      logic             avg_load;
      logic             seg_load;
      logic             mul_load;
      logic             mul_add;
      logic             out_load;
   } apls_cmd_type;

   typedef struct packed {
      logic sample_fire;
      logic last_sample;
      logic div_busy;
      logic direct;
      logic out_busy;
   } apls_status_type;

endpackage

// ----- rtl/apls_req_if.sv -----
interface apls_req_if;
   logic                            valid;
   logic                            ready;
   logic [apls_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/apls_rsp_if.sv -----
interface apls_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [apls_pkg::VALUE_W-1:0]  reading;
   logic                                 sensor_open;
   logic [apls_pkg::SAMPLE_W-1:0]        average;

   modport source (output valid, output reading, output sensor_open, output average,
                   input ready);
   modport sink   (input valid, input reading, input sensor_open, input average,
                   output ready);
endinterface

// ----- rtl/averaged_piecewise_linear_sensor.sv -----
// Samples are taken one per cycle while the block accumulates a group.
// After the last sample of a group the block averages, picks the segment and
// multiplies, then runs one shift-subtract divider unless no interpolation is needed.
// No new samples are taken until the reading is loaded, and a result
// left waiting holds the block. Reset (synchronous, active high) clears sum,
// count, state and output valid, and loads the default calibration registers.
module averaged_piecewise_linear_sensor #(
   parameter int SAMPLES_PER_RESULT = apls_pkg::SAMPLES_PER_RESULT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [apls_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [apls_pkg::CFG_DATA_W-1:0]   csr_wdata,
   apls_req_if.sink                          req_chan,
   apls_rsp_if.source                        rsp_chan
);

   // Controller sequences the datapath:
   //   accumulate -> scale sum by the reciprocal of the group size -> pick
   //   segment and levels -> level * width, add offset * step -> divide by
   //   width -> saturate.
   // Out-of-range, open-sensor and zero-width cases skip the division.
   apls_pkg::apls_cmd_type    cmd;
   apls_pkg::apls_status_type status;

   apls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath holds the configuration, the accumulator, the divider,
   // the multiplier and the result register that parts the output side.
   apls_datapath #(
      .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ----- rtl/apls_div.sv -----
module apls_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [apls_pkg::DIV_W-1:0]   dividend,
   input  logic [apls_pkg::DEN_W-1:0]   divisor,
   output logic                         busy,
   output logic [apls_pkg::DIV_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(apls_pkg::DIV_W);
   localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(apls_pkg::DIV_W - 1);

   logic                          busy_ff, busy_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [apls_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [apls_pkg::DEN_W-1:0]    dvs_ff, dvs_in;
   logic [apls_pkg::DIV_W-1:0]    quo_ff, quo_in;
   logic [apls_pkg::DEN_W:0]      shifted;
   logic                          fits;

   // One restoring step a cycle, quotient bits shift in from the right
   always_comb begin
      shifted = {rem_ff, quo_ff[apls_pkg::DIV_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = apls_pkg::DEN_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[apls_pkg::DEN_W-1:0];
         end
         quo_in = {quo_ff[apls_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_ITER) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/apls_datapath.sv -----
module apls_datapath #(
   parameter int SAMPLES_PER_RESULT = apls_pkg::SAMPLES_PER_RESULT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [apls_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [apls_pkg::CFG_DATA_W-1:0]   csr_wdata,
   apls_req_if.sink                          req_chan,
   apls_rsp_if.source                        rsp_chan,
   input  apls_pkg::apls_cmd_type            cmd,
   output apls_pkg::apls_status_type         status
);

   localparam int CNT_W  = (SAMPLES_PER_RESULT > 1) ? $clog2(SAMPLES_PER_RESULT) : 1;
   localparam int SUM_W  = apls_pkg::SAMPLE_W + $clog2(SAMPLES_PER_RESULT);
   localparam int MB_W   = apls_pkg::BREAK_W + 2;
   localparam int PROD_W = apls_pkg::LEVEL_W + MB_W;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_RESULT - 1);
   // Average by reciprocal: ceil(2^AVG_SHIFT / N) gives the exact floor for
   // every sum below 2^SUM_W.
   localparam int AVG_SHIFT  = SUM_W + $clog2(SAMPLES_PER_RESULT);
   localparam int RECIP_W    = SUM_W + 2;
   localparam int AVG_PROD_W = SUM_W + RECIP_W;
   localparam longint AVG_RECIP_L =
      ((longint'(1) << AVG_SHIFT) + longint'(SAMPLES_PER_RESULT) - 1)
      / longint'(SAMPLES_PER_RESULT);
   localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_L);

   function automatic logic signed [apls_pkg::VALUE_W-1:0] sat_q88(
      input logic signed [apls_pkg::DIV_W:0] v);
      logic signed [apls_pkg::VALUE_W-1:0] r;
      if (v > 33'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[apls_pkg::VALUE_W-1:0];
      end
      return r;
   endfunction

   // Configuration registers
   logic [apls_pkg::BREAK_W-1:0] break_ff [apls_pkg::NUM_BREAKS];
   logic [apls_pkg::VALUE_W-1:0] base_ff, step_ff;
   logic [apls_pkg::BREAK_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         break_ff[0] <= apls_pkg::BREAK_0_RST;
         break_ff[1] <= apls_pkg::BREAK_1_RST;
         break_ff[2] <= apls_pkg::BREAK_2_RST;
         break_ff[3] <= apls_pkg::BREAK_3_RST;
         break_ff[4] <= apls_pkg::BREAK_4_RST;
         base_ff     <= apls_pkg::VALUE_BASE_RST;
         step_ff     <= apls_pkg::VALUE_STEP_RST;
         limit_ff    <= apls_pkg::OPEN_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            apls_pkg::REG_BREAK_0:    break_ff[0] <= csr_wdata[apls_pkg::BREAK_W-1:0];
            apls_pkg::REG_BREAK_1:    break_ff[1] <= csr_wdata[apls_pkg::BREAK_W-1:0];
            apls_pkg::REG_BREAK_2:    break_ff[2] <= csr_wdata[apls_pkg::BREAK_W-1:0];
            apls_pkg::REG_BREAK_3:    break_ff[3] <= csr_wdata[apls_pkg::BREAK_W-1:0];
            apls_pkg::REG_BREAK_4:    break_ff[4] <= csr_wdata[apls_pkg::BREAK_W-1:0];
            apls_pkg::REG_VALUE_BASE: base_ff     <= csr_wdata;
            apls_pkg::REG_VALUE_STEP: step_ff     <= csr_wdata;
            apls_pkg::REG_OPEN_LIMIT: limit_ff    <= csr_wdata[apls_pkg::BREAK_W-1:0];
            default:                  limit_ff    <= limit_ff;
         endcase
      end
   end

   // Sample accumulation
   logic                  fire;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  last_sample;

   assign req_chan.ready = cmd.take;
   assign fire           = cmd.take && req_chan.valid;
   assign last_sample    = (cnt_ff == LAST_CNT);

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (cmd.avg_load) begin
         sum_in = '0;
      end else if (fire) begin
         sum_in = sum_ff + SUM_W'(req_chan.sample);
         cnt_in = last_sample ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   // Average: one multiply by the rounded-up reciprocal of the group size
   logic [AVG_PROD_W-1:0]         avg_prod;
   logic [apls_pkg::BREAK_W-1:0]  avg_ff;

   assign avg_prod = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.avg_load) begin
         avg_ff <= avg_prod[AVG_SHIFT +: apls_pkg::SAMPLE_W];
      end
   end

   // Interpolation divider
   logic                          div_busy;
   logic [apls_pkg::DIV_W-1:0]    quotient;
   logic [apls_pkg::DIV_W-1:0]    dividend;
   logic [apls_pkg::DEN_W-1:0]    divisor;
   logic signed [apls_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [apls_pkg::BREAK_W-1:0]  den_ff, diff_ff;

   // Divide the magnitude, restore the sign afterwards
   assign dividend = acc_ff[apls_pkg::ACC_W-1] ? apls_pkg::DIV_W'(-acc_ff)
                                               : apls_pkg::DIV_W'(acc_ff);
   assign divisor  = den_ff;

   apls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Segment search and breakpoint levels
   logic signed [apls_pkg::LEVEL_W-1:0] base_x, step_x;
   logic signed [apls_pkg::LEVEL_W-1:0] lev [apls_pkg::NUM_BREAKS];
   logic [apls_pkg::NUM_SEGS-1:0]       hit;
   logic                                below, open_c, direct_c;
   logic [apls_pkg::BREAK_W-1:0]        den_c, diff_c;
   logic signed [apls_pkg::LEVEL_W-1:0] lev_c, dval_c;

   assign base_x = {{(apls_pkg::LEVEL_W-apls_pkg::VALUE_W){base_ff[apls_pkg::VALUE_W-1]}},
                    base_ff};
   assign step_x = {{(apls_pkg::LEVEL_W-apls_pkg::VALUE_W){step_ff[apls_pkg::VALUE_W-1]}},
                    step_ff};

   always_comb begin
      for (int k = 0; k < apls_pkg::NUM_BREAKS; k++) begin
         lev[k] = base_x + step_x * $signed(apls_pkg::LEVEL_W'(k));
      end
      for (int k = 0; k < apls_pkg::NUM_SEGS; k++) begin
         hit[k] = (break_ff[k] <= avg_ff) && (avg_ff <= break_ff[k+1]);
      end
      below  = avg_ff < break_ff[0];
      open_c = avg_ff >= limit_ff;
      den_c  = '0;
      diff_c = '0;
      lev_c  = lev[apls_pkg::NUM_SEGS];
      // Lowest matching segment wins
      for (int k = apls_pkg::NUM_SEGS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            den_c  = break_ff[k+1] - break_ff[k];
            diff_c = avg_ff - break_ff[k];
            lev_c  = lev[k];
         end
      end
      if (open_c || (!below && !(|hit))) begin
         dval_c = lev[apls_pkg::NUM_SEGS];
      end else if (below) begin
         dval_c = lev[0];
      end else begin
         dval_c = lev_c;
      end
      direct_c = open_c || below || !(|hit) || (den_c == '0);
   end

   logic                                open_ff, direct_ff;
   logic signed [apls_pkg::LEVEL_W-1:0] level_ff, dval_ff;

   always_ff @(posedge clock) begin
      if (cmd.seg_load) begin
         open_ff   <= open_c;
         direct_ff <= direct_c;
         dval_ff   <= dval_c;
         level_ff  <= lev_c;
         den_ff    <= den_c;
         diff_ff   <= diff_c;
      end
   end

   // Numerator: level * den, then add (avg - segment start) * step on the same multiplier
   logic signed [apls_pkg::LEVEL_W-1:0] mul_a;
   logic signed [MB_W-1:0]              mul_b;
   logic signed [PROD_W-1:0]            product;

   always_comb begin
      if (cmd.mul_add) begin
         mul_a = step_x;
         mul_b = $signed({2'b00, diff_ff});
      end else begin
         mul_a = level_ff;
         mul_b = $signed({2'b00, den_ff});
      end
      product = PROD_W'(mul_a) * PROD_W'(mul_b);
      acc_in  = acc_ff;
      if (cmd.mul_load) begin
         acc_in = apls_pkg::ACC_W'(product);
      end else if (cmd.mul_add) begin
         acc_in = acc_ff + apls_pkg::ACC_W'(product);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Result register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [apls_pkg::VALUE_W-1:0]   reading_ff;
   logic                                  sensor_open_ff;
   logic [apls_pkg::SAMPLE_W-1:0]         average_ff;
   logic signed [apls_pkg::DIV_W:0]       q_signed, dval_wide;
   logic                                  out_busy;

   assign out_busy  = rsp_valid_ff && !rsp_chan.ready;
   assign q_signed  = acc_ff[apls_pkg::ACC_W-1] ? -$signed({1'b0, quotient})
                                                 :  $signed({1'b0, quotient});
   assign dval_wide = {{(apls_pkg::DIV_W+1-apls_pkg::LEVEL_W){dval_ff[apls_pkg::LEVEL_W-1]}},
                       dval_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         reading_ff     <= sat_q88(direct_ff ? dval_wide : q_signed);
         sensor_open_ff <= open_ff;
         average_ff     <= avg_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.reading     = reading_ff;
   assign rsp_chan.sensor_open = sensor_open_ff;
   assign rsp_chan.average     = average_ff;

   assign status.sample_fire = fire;
   assign status.last_sample = last_sample;
   assign status.div_busy    = div_busy;
   assign status.direct      = direct_ff;
   assign status.out_busy    = out_busy;

   // Never restart the divider mid-run
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_busy)
      else $error("result register overwritten");

   // Average always fits the sample width
   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      cmd.avg_load |-> (avg_prod[AVG_PROD_W-1:AVG_SHIFT+apls_pkg::SAMPLE_W] == '0))
      else $error("average out of range");

   // Interpolated result needs a nonzero segment width
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !direct_ff) |-> (den_ff != '0))
      else $error("interpolation with zero segment width");

endmodule

// ----- rtl/apls_ctrl.sv -----
module apls_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  apls_pkg::apls_status_type   status,
   output apls_pkg::apls_cmd_type      cmd
);

   apls_pkg::apls_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apls_pkg::ST_ACCUM: begin
            if (status.sample_fire && status.last_sample) begin
               state_in = apls_pkg::ST_AVERAGE;
            end
         end
         apls_pkg::ST_AVERAGE: state_in = apls_pkg::ST_SEGMENT;
         apls_pkg::ST_SEGMENT: state_in = apls_pkg::ST_MUL_LEVEL;
         apls_pkg::ST_MUL_LEVEL: begin
            state_in = status.direct ? apls_pkg::ST_FINISH : apls_pkg::ST_MUL_SLOPE;
         end
         apls_pkg::ST_MUL_SLOPE: state_in = apls_pkg::ST_NUM_START;
         apls_pkg::ST_NUM_START: state_in = apls_pkg::ST_NUM_WAIT;
         apls_pkg::ST_NUM_WAIT: begin
            if (!status.div_busy) begin
               state_in = apls_pkg::ST_FINISH;
            end
         end
         apls_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = apls_pkg::ST_ACCUM;
            end
         end
         default: state_in = apls_pkg::ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         apls_pkg::ST_ACCUM:     cmd.take = 1'b1;
         apls_pkg::ST_AVERAGE:   cmd.avg_load = 1'b1;
         apls_pkg::ST_SEGMENT:   cmd.seg_load = 1'b1;
         apls_pkg::ST_MUL_LEVEL: cmd.mul_load = 1'b1;
         apls_pkg::ST_MUL_SLOPE: cmd.mul_add = 1'b1;
         apls_pkg::ST_NUM_START: cmd.div_start = 1'b1;
         apls_pkg::ST_NUM_WAIT:  cmd = '0;
         apls_pkg::ST_FINISH:    cmd.out_load = !status.out_busy;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apls_pkg::ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- bench/averaged_piecewise_linear_sensor_tb.sv -----
`timescale 1ns / 1ps

module averaged_piecewise_linear_sensor_tb;
   import apls_pkg::*;

   // Samples per reading; passed to the block so the predictor and the RTL agree.
   localparam int GROUP        = SAMPLES_PER_RESULT_DEF;
   // Extra wait once every sample is taken and every reading has arrived.
   localparam int DRAIN_CYCLES = 120;
   // Slowest correct gap without a transaction: long source gap, long sink stall,
   // divider latency and a configuration pause. Several times that.
   localparam int STALL_LIMIT  = 3000;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
   localparam longint READING_MAX = 32767;
   localparam longint READING_MIN = -32768;

   typedef struct packed {
      logic signed [VALUE_W-1:0] reading;
      logic                      sensor_open;
      logic [SAMPLE_W-1:0]       average;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CFG_IDX_W-1:0]  csr_index;
   logic [CFG_DATA_W-1:0] csr_wdata;

   apls_req_if req_chan ();
   apls_rsp_if rsp_chan ();

   averaged_piecewise_linear_sensor #(
      .SAMPLES_PER_RESULT(GROUP)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the calibration registers, updated as they are written.
   logic [BREAK_W-1:0]        brk_cfg [NUM_BREAKS];
   logic signed [VALUE_W-1:0] base_cfg;
   logic signed [VALUE_W-1:0] step_cfg;
   logic [BREAK_W-1:0]        open_cfg;

   // Shadow accumulator of the group in progress.
   logic [19:0] acc_sum;
   int          acc_count;

   logic [SAMPLE_W-1:0] sample_q [$];    // samples waiting to be driven
   reading_type         reading_q [$];   // readings the block still owes us
   reading_type         head;
   int                  samples_queued;
   int                  samples_taken;
   int                  fail_count;
   int                  idle_cycles;
   int                  send_gap;
   int                  recv_gap;
   bit                  steady;          // no idling on either side while set

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, a few long ones; none at all in steady phases.
   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Output level at breakpoint k, kept wide so overflow is visible before saturation.
   function automatic longint level_at(int k);
      return longint'(base_cfg) + longint'(k) * longint'(step_cfg);
   endfunction

   // Piecewise-linear map of an average. Segments are tried in order and the
   // first match wins; bounds are inclusive; signed division truncates toward zero.
   function automatic longint interpolate(logic [SAMPLE_W-1:0] avg);
      longint den;
      longint num;
      if (avg < brk_cfg[0])
         return level_at(0);
      for (int k = 0; k < NUM_SEGS; k++) begin
         if (brk_cfg[k] <= avg && avg <= brk_cfg[k+1]) begin
            den = longint'(brk_cfg[k+1]) - longint'(brk_cfg[k]);
            // Coincident breakpoints: take the level, no division.
            if (den == 0)
               return level_at(k);
            num = level_at(k) * den
                + (longint'(avg) - longint'(brk_cfg[k])) * longint'(step_cfg);
            return num / den;
         end
      end
      // Unordered breakpoints with no matching segment fall to the top level.
      return level_at(NUM_SEGS);
   endfunction

   // Fold one accepted sample into the shadow accumulator; on the last sample
   // of a group, queue the reading the block must produce.
   function automatic void absorb_sample(logic [SAMPLE_W-1:0] s);
      reading_type r;
      longint      value;
      acc_sum = acc_sum + 20'(s);
      if (acc_count + 1 < GROUP) begin
         acc_count++;
         return;
      end
      r.average     = SAMPLE_W'(acc_sum / GROUP);
      acc_sum       = '0;
      acc_count     = 0;
      r.sensor_open = (r.average >= open_cfg);
      // An open sensor reads the top level whatever the segment.
      value = r.sensor_open ? level_at(NUM_SEGS) : interpolate(r.average);
      if (value > READING_MAX)
         value = READING_MAX;
      else if (value < READING_MIN)
         value = READING_MIN;
      r.reading = VALUE_W'(value);
      reading_q.push_back(r);
   endfunction

   function automatic void push_sample(int s);
      sample_q.push_back(SAMPLE_W'(s));
      samples_queued++;
   endfunction

   // Queue one aligned group of samples scattered around a target average.
   // Pad with random samples first if a stray tail left the stream misaligned.
   function automatic void push_group(int target, int spread);
      int s;
      while (samples_queued % GROUP != 0)
         push_sample($urandom_range(0, SAMPLE_MAX));
      for (int i = 0; i < GROUP; i++) begin
         s = target + int'($urandom_range(0, 2 * spread)) - spread;
         push_sample(s < 0 ? 0 : (s > SAMPLE_MAX ? SAMPLE_MAX : s));
      end
   endfunction

   // Random groups aimed mostly at the interesting spots: breakpoints, the open
   // limit, then broad averages and plain noise. Drop in a stray partial group now and then.
   function automatic void push_random_groups(int count);
      int kind;
      for (int g = 0; g < count; g++) begin
         kind = $urandom_range(0, 99);
         if (kind < 40)
            push_group(int'(brk_cfg[$urandom_range(0, NUM_BREAKS - 1)])
                       + int'($urandom_range(0, 4)) - 2, $urandom_range(0, 3));
         else if (kind < 55)
            push_group(int'(open_cfg) + int'($urandom_range(0, 4)) - 2,
                       $urandom_range(0, 2));
         else if (kind < 85)
            push_group($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 400));
         else
            push_group(SAMPLE_MAX / 2 + 1, SAMPLE_MAX / 2 + 1);
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, GROUP - 1))
               push_sample($urandom_range(0, SAMPLE_MAX));
      end
   endfunction

   task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_VALUE_BASE: base_cfg = data;
         REG_VALUE_STEP: step_cfg = data;
         REG_OPEN_LIMIT: open_cfg = data[BREAK_W-1:0];
         default:        brk_cfg[idx] = data[BREAK_W-1:0];
      endcase
   endtask

   // Write every register. The 12-bit registers get junk in the unused upper bits.
   task automatic load_config(int b0, int b1, int b2, int b3, int b4,
                              int base, int step, int limit);
      int pts [NUM_BREAKS];
      pts = '{b0, b1, b2, b3, b4};
      for (int k = 0; k < NUM_BREAKS; k++)
         write_reg(CFG_IDX_W'(REG_BREAK_0 + k), {4'($urandom), BREAK_W'(pts[k])});
      write_reg(REG_VALUE_BASE, VALUE_W'(base));
      write_reg(REG_VALUE_STEP, VALUE_W'(step));
      write_reg(REG_OPEN_LIMIT, {4'($urandom), BREAK_W'(limit)});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Random calibration: usually ascending breakpoints, sometimes left unordered;
   // levels either moderate or anywhere in the 16-bit range.
   task automatic load_random_config();
      int pts [$];
      int base;
      int step;
      int limit;
      repeat (NUM_BREAKS)
         pts.push_back($urandom_range(0, SAMPLE_MAX));
      if ($urandom_range(0, 4) != 0)
         pts.sort();
      if ($urandom_range(0, 1) == 0) begin
         base = int'($urandom_range(0, 4000)) - 2000;
         step = int'($urandom_range(0, 3000)) - 1500;
      end else begin
         base = int'($urandom_range(0, 65535)) - 32768;
         step = int'($urandom_range(0, 65535)) - 32768;
      end
      if ($urandom_range(0, 9) < 7)
         limit = $urandom_range(SAMPLE_MAX / 2, SAMPLE_MAX);
      else
         limit = $urandom_range(0, SAMPLE_MAX);
      load_config(pts[0], pts[1], pts[2], pts[3], pts[4], base, step, limit);
   endtask

   // Wait for every queued sample to be taken and every reading to arrive, then
   // give the divider time to finish anything still in flight.
   task automatic settle();
      while (samples_taken < samples_queued || reading_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Driver: present the next sample once the previous transaction is done and
   // the current gap has run out; hold valid and data while the block stalls.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            absorb_sample(req_chan.sample);
            samples_taken <= samples_taken + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap       <= send_gap - 1;
            end else if (sample_q.size() > 0) begin
               req_chan.valid  <= 1'b1;
               req_chan.sample <= sample_q.pop_front();
               send_gap        <= pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall ready at random and compare every reading transaction with
   // the oldest one the predictor queued.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap       <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (reading_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected reading: reading %0d open %0b average %0d",
                           rsp_chan.reading, rsp_chan.sensor_open, rsp_chan.average);
               fail_count++;
            end else begin
               head = reading_q.pop_front();
               if (rsp_chan.reading !== head.reading
                   || rsp_chan.sensor_open !== head.sensor_open
                   || rsp_chan.average !== head.average) begin
                  if (fail_count < 10)
                     $display({"reading mismatch: expected reading %0d open %0b average %0d,",
                               " got reading %0d open %0b average %0d"},
                              head.reading, head.sensor_open, head.average,
                              rsp_chan.reading, rsp_chan.sensor_open, rsp_chan.average);
                  fail_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            rsp_chan.ready <= 1'b0;
            recv_gap       <= recv_gap - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
            recv_gap       <= pick_gap();
         end
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Drive every input to a known value before the first edge.
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      rsp_chan.ready  = 1'b0;
      brk_cfg  = '{BREAK_0_RST, BREAK_1_RST, BREAK_2_RST, BREAK_3_RST, BREAK_4_RST};
      base_cfg = VALUE_BASE_RST;
      step_cfg = VALUE_STEP_RST;
      open_cfg = OPEN_LIMIT_RST;
      acc_sum        = '0;
      acc_count      = 0;
      samples_queued = 0;
      samples_taken  = 0;
      fail_count     = 0;
      idle_cycles    = 0;
      steady         = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset calibration: floor, ceiling, exact breakpoints, just past the last
      // breakpoint, both sides of the open limit, and an average that rounds down.
      push_group(0, 0);
      push_group(SAMPLE_MAX, 0);
      push_group(161, 0);
      push_group(776, 0);
      push_group(1613, 0);
      push_group(1614, 0);
      push_group(1999, 0);
      push_group(2000, 0);
      for (int i = 0; i < GROUP; i++)
         push_sample(1000 + i % 2);
      push_random_groups(4);
      settle();

      // Coincident breakpoints and a falling curve: negative quotients truncate
      // toward zero. Hit the flat first segment, mid-segment, a shared breakpoint,
      // below the first and above the last breakpoint.
      load_config(100, 100, 900, 900, 3000, -1000, -333, SAMPLE_MAX);
      push_group(100, 0);
      push_group(500, 0);
      push_group(900, 0);
      push_group(3500, 0);
      push_group(50, 0);
      push_random_groups(4);
      settle();

      // Largest levels: interpolation and the open level both saturate high.
      // Run this phase with no idling at all.
      steady = 1'b1;
      load_config(0, 1000, 2000, 3000, SAMPLE_MAX, 32767, 32767, SAMPLE_MAX);
      push_group(500, 0);
      push_group(SAMPLE_MAX, 0);
      push_random_groups(3);
      settle();
      steady = 1'b0;

      // Most negative levels with a zero open limit: every average reads open
      // and the top level saturates low.
      load_config(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                  -32768, -32768, 0);
      push_group(0, 0);
      push_random_groups(2);
      settle();

      // Unordered breakpoints: an average that fits no segment takes the top
      // level; one below the first breakpoint takes the base level.
      load_config(3000, 500, 2500, 1000, 200, 256, -100, 4000);
      push_group(3500, 0);
      push_group(700, 0);
      push_random_groups(3);
      settle();

      // Random calibrations, one of them without idling.
      for (int p = 0; p < 4; p++) begin
         steady = (p == 2);
         load_random_config();
         push_random_groups(5);
         settle();
      end

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
